// File: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; clock clk and active-low reset rst_n assumed in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define CHK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define CHK_NEVER(lbl, expr, msg) \
  `CHK_ASSERT(lbl, !(expr), msg)

`endif

// File: hw/rtl/cwmt_pkg.sv
// shared types, codes and defaults for the channel window message-id tracker
// no dependencies
package cwmt_pkg;

  // default sizes
  localparam int WINDOW_MAX_DEF = 8;
  localparam int CHANNELS_DEF   = 8;

  // channel number constants
  localparam logic [31:0] CHAN_ALL_ONES = 32'hffff_ffff;
  localparam int          CTRL_LSB      = 24;
  localparam int          CTRL_W        = 7;

  // operation codes
  localparam logic [2:0] OP_OPEN      = 3'd0;
  localparam logic [2:0] OP_CLOSE     = 3'd1;
  localparam logic [2:0] OP_CLOSE_CTL = 3'd2;
  localparam logic [2:0] OP_SEND      = 3'd3;
  localparam logic [2:0] OP_CONFIRM   = 3'd4;

  // result status codes
  localparam logic [2:0] STS_OK         = 3'd0;
  localparam logic [2:0] STS_WIN_FULL   = 3'd1;
  localparam logic [2:0] STS_ID_MISSING = 3'd2;
  localparam logic [2:0] STS_UNKNOWN    = 3'd3;
  localparam logic [2:0] STS_TABLE_FULL = 3'd4;
  localparam logic [2:0] STS_NOT_FOUND  = 3'd5;

  // input beat
  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  app_id;
    logic [31:0] chan_number;
    logic [15:0] message_id;
    logic [7:0]  window_req;
    logic [6:0]  controller_num;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [2:0] status;
    logic [3:0] closed_count;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic look;
    logic rd_en;
    logic pass2;
    logic finish;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan;
    logic found;
  } dp_stat_t;

endpackage

// File: hw/rtl/cwmt_ctrl.sv
// sequencer for the tracker: lookup, slot scans and result timing
// depends on cwmt_pkg
module cwmt_ctrl #(
  parameter int  WINDOW_MAX = cwmt_pkg::WINDOW_MAX_DEF,
  localparam int SW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  cwmt_pkg::dp_stat_t stat,
  output cwmt_pkg::dp_cmd_t  cmd,
  output logic [SW-1:0]      rd_slot
);
  import cwmt_pkg::*;

  localparam int CW = $clog2(WINDOW_MAX + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOOK  = 6'b000010,
    S_SCAN1 = 6'b000100,
    S_CHK   = 6'b001000,
    S_SCAN2 = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          cnt_end;

  assign cnt_end = (cnt_r == CW'(WINDOW_MAX));
  assign busy    = (state_r != S_IDLE);
  assign rd_slot = cnt_r[SW-1:0];

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = stat.scan ? S_SCAN1 : S_FIN;
      end
      S_SCAN1: begin
        cmd.rd_en = !cnt_end;
        if (cnt_end) begin
          cnt_nxt   = '0;
          state_nxt = S_CHK;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_CHK: begin
        state_nxt = stat.found ? S_SCAN2 : S_FIN;
      end
      S_SCAN2: begin
        cmd.pass2 = 1'b1;
        cmd.rd_en = !cnt_end;
        if (cnt_end) begin
          cnt_nxt   = '0;
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// File: hw/rtl/cwmt_dp.sv
// datapath: channel table, outstanding-slot flags, slot memory and result register
// depends on cwmt_pkg
module cwmt_dp #(
  parameter int  WINDOW_MAX = cwmt_pkg::WINDOW_MAX_DEF,
  parameter int  CHANNELS   = cwmt_pkg::CHANNELS_DEF,
  localparam int SW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cwmt_pkg::in_item_t  in_item,
  input  cwmt_pkg::dp_cmd_t   cmd,
  input  logic [SW-1:0]       rd_slot,
  output cwmt_pkg::dp_stat_t  stat,
  output logic                out_valid,
  output cwmt_pkg::out_item_t out_item
);
  import cwmt_pkg::*;

  localparam int CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int WW  = $clog2(WINDOW_MAX + 1);
  localparam int CLW = $clog2(CHANNELS + 1);
  localparam int AW  = CIW + SW;
  localparam int MD  = 1 << AW;
  localparam int DW  = SW + 16;

  // held item
  in_item_t item_r;

  // channel table
  logic [CHANNELS-1:0]   valid_r;
  logic [7:0]            owner_r [CHANNELS];
  logic [31:0]           key_r   [CHANNELS];
  logic [WW-1:0]         win_r   [CHANNELS];
  logic [WINDOW_MAX-1:0] busy_r  [CHANNELS];

  // slot memory: {age, id}
  logic [DW-1:0] mem [MD];
  logic [DW-1:0] mem_q_r;
  logic          rd_v_r;
  logic [SW-1:0] rd_slot_r;
  logic          rd_p2_r;

  // lookup results
  logic                hit, free_ok;
  logic [CIW-1:0]      hidx, fidx;
  logic [CHANNELS-1:0] ctlm;
  logic                hit_r, free_ok_r;
  logic [CIW-1:0]      hidx_r, fidx_r;
  logic [CHANNELS-1:0] ctlm_r;

  // best match of the confirm scan
  logic          best_ok_r;
  logic [SW-1:0] best_slot_r;
  logic [SW-1:0] best_age_r;

  // finish stage
  logic [WINDOW_MAX-1:0] row;
  logic [WW-1:0]         n_busy;
  logic [SW-1:0]         ffree;
  logic [WW-1:0]         new_win;
  logic [CLW-1:0]        ctl_cnt;
  logic [3:0]            closed;
  logic [2:0]            status;
  logic                  is_cc;
  logic [CIW-1:0]        cidx;
  logic                  open_ok, send_ok, conf_ok;

  // memory write side
  logic          we;
  logic [AW-1:0] waddr;
  logic [DW-1:0] wdata;
  logic [SW-1:0] q_age;
  logic [15:0]   q_id;
  logic          q_busy;

  logic     out_valid_r;
  out_item_t out_r;

  // channel lookup over the table
  always_comb begin
    hit     = 1'b0;
    hidx    = '0;
    free_ok = 1'b0;
    fidx    = '0;
    ctlm    = '0;
    for (int c = CHANNELS - 1; c >= 0; c--) begin
      if (valid_r[c] && owner_r[c] == item_r.app_id && key_r[c] == item_r.chan_number) begin
        hit  = 1'b1;
        hidx = CIW'(c);
      end
      if (!valid_r[c]) begin
        free_ok = 1'b1;
        fidx    = CIW'(c);
      end
      ctlm[c] = valid_r[c] && owner_r[c] == item_r.app_id &&
                key_r[c][CTRL_LSB +: CTRL_W] == item_r.controller_num;
    end
  end

  assign stat.scan  = (item_r.op == OP_CONFIRM) && hit;
  assign stat.found = best_ok_r;

  // item and lookup registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    if (cmd.look) begin
      hit_r     <= hit;
      hidx_r    <= hidx;
      free_ok_r <= free_ok;
      fidx_r    <= fidx;
      ctlm_r    <= ctlm;
    end
  end

  // window row of the found channel
  assign row    = busy_r[hidx_r];
  assign q_age  = mem_q_r[DW-1:16];
  assign q_id   = mem_q_r[15:0];
  assign q_busy = row[rd_slot_r];

  // occupancy, first free slot, clamped window, closed count
  always_comb begin
    n_busy = '0;
    ffree  = '0;
    for (int s = WINDOW_MAX - 1; s >= 0; s--) begin
      n_busy = n_busy + WW'(row[s]);
      if (!row[s]) begin
        ffree = SW'(s);
      end
    end
    if (item_r.window_req > 8'(WINDOW_MAX)) begin
      new_win = WW'(WINDOW_MAX);
    end else if (item_r.window_req == 8'd0) begin
      new_win = WW'(1);
    end else begin
      new_win = WW'(item_r.window_req);
    end
    ctl_cnt = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      ctl_cnt = ctl_cnt + CLW'(ctlm_r[c]);
    end
  end

  // result and action decode
  always_comb begin
    is_cc   = (item_r.op == OP_CLOSE_CTL) ||
              (item_r.op == OP_CLOSE && item_r.chan_number == CHAN_ALL_ONES);
    cidx    = (item_r.op == OP_OPEN && !hit_r) ? fidx_r : hidx_r;
    open_ok = hit_r || free_ok_r;
    send_ok = hit_r && (n_busy < win_r[hidx_r]);
    conf_ok = hit_r && best_ok_r;
    status  = STS_OK;
    closed  = 4'd0;
    case (item_r.op)
      OP_OPEN: begin
        if (!open_ok) status = STS_TABLE_FULL;
      end
      OP_CLOSE, OP_CLOSE_CTL: begin
        if (is_cc) begin
          closed = (ctl_cnt > CLW'(15)) ? 4'd15 : 4'(ctl_cnt);
        end else if (hit_r) begin
          closed = 4'd1;
        end else begin
          status = STS_NOT_FOUND;
        end
      end
      OP_SEND: begin
        if (!hit_r) status = STS_UNKNOWN;
        else if (!send_ok) status = STS_WIN_FULL;
      end
      OP_CONFIRM: begin
        if (!hit_r) status = STS_UNKNOWN;
        else if (!best_ok_r) status = STS_ID_MISSING;
      end
      default: begin
        status = STS_OK;
      end
    endcase
  end

  // table updates at finish
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        busy_r[c] <= '0;
      end
    end else if (cmd.finish) begin
      case (item_r.op)
        OP_OPEN: begin
          if (open_ok) begin
            valid_r[cidx] <= 1'b1;
            owner_r[cidx] <= item_r.app_id;
            key_r[cidx]   <= item_r.chan_number;
            win_r[cidx]   <= new_win;
            busy_r[cidx]  <= '0;
          end
        end
        OP_CLOSE, OP_CLOSE_CTL: begin
          if (is_cc) begin
            for (int c = 0; c < CHANNELS; c++) begin
              if (ctlm_r[c]) begin
                valid_r[c] <= 1'b0;
                busy_r[c]  <= '0;
              end
            end
          end else if (hit_r) begin
            valid_r[hidx_r] <= 1'b0;
            busy_r[hidx_r]  <= '0;
          end
        end
        OP_SEND: begin
          if (send_ok) busy_r[hidx_r][ffree] <= 1'b1;
        end
        OP_CONFIRM: begin
          if (conf_ok) busy_r[hidx_r][best_slot_r] <= 1'b0;
        end
        default: begin
          valid_r <= valid_r;
        end
      endcase
    end
  end

  // read pipeline tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= cmd.rd_en;
    end
    rd_slot_r <= rd_slot;
    rd_p2_r   <= cmd.pass2;
  end

  // oldest matching id, first pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_ok_r <= 1'b0;
    end else if (cmd.look) begin
      best_ok_r <= 1'b0;
    end else if (rd_v_r && !rd_p2_r && q_busy && q_id == item_r.message_id &&
                 (!best_ok_r || q_age < best_age_r)) begin
      best_ok_r <= 1'b1;
    end
    if (rd_v_r && !rd_p2_r && q_busy && q_id == item_r.message_id &&
        (!best_ok_r || q_age < best_age_r)) begin
      best_slot_r <= rd_slot_r;
      best_age_r  <= q_age;
    end
  end

  // memory write: new id on send, age shift on the second pass
  always_comb begin
    we    = 1'b0;
    waddr = {hidx_r, ffree};
    wdata = {n_busy[SW-1:0], item_r.message_id};
    if (cmd.finish && item_r.op == OP_SEND && send_ok) begin
      we = 1'b1;
    end else if (rd_v_r && rd_p2_r && q_busy && q_age > best_age_r) begin
      we    = 1'b1;
      waddr = {hidx_r, rd_slot_r};
      wdata = {q_age - 1'b1, q_id};
    end
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      mem_q_r <= mem[{hidx_r, rd_slot}];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
    if (cmd.finish) begin
      out_r.status       <= status;
      out_r.closed_count <= closed;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// File: hw/rtl/channel_window_msgid_tracker.sv
// Sequence: an accepted item is loaded, looked up in the channel table and finished, and its
// result strobe is registered; a confirm on a known channel sweeps the slot memory once and, if
// the id is found, again, one slot per cycle through its single read port. A new item is taken
// only once the last one is finished and the block is idle; the receiver cannot stall results.
// Reset (synchronous, rst_n low) empties the channel table and all slot flags at once.
// depends on cwmt_pkg, cwmt_ctrl, cwmt_dp
module channel_window_msgid_tracker #(
  parameter int WINDOW_MAX = cwmt_pkg::WINDOW_MAX_DEF,
  parameter int CHANNELS   = cwmt_pkg::CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  cwmt_pkg::in_item_t  in_item,
  output logic                out_valid,
  output cwmt_pkg::out_item_t out_item
);
  import cwmt_pkg::*;

  localparam int SW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  dp_cmd_t       cmd;
  dp_stat_t      stat;
  logic [SW-1:0] rd_slot;

  // sequencer
  cwmt_ctrl #(.WINDOW_MAX(WINDOW_MAX)) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .stat    (stat),
    .cmd     (cmd),
    .rd_slot (rd_slot)
  );

  // table and slot storage
  cwmt_dp #(.WINDOW_MAX(WINDOW_MAX), .CHANNELS(CHANNELS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .rd_slot   (rd_slot),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// File: hw/rtl/cwmt_checker.sv
// port-level checks for the tracker, bound to the top level
// depends on cwmt_pkg and assert_macros.svh
`include "assert_macros.svh"

module cwmt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input cwmt_pkg::out_item_t out_item
);
  import cwmt_pkg::*;

  // an accepted beat makes the block busy
  `CHK_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accept did not raise busy")

  // a result only follows work in progress
  `CHK_ASSERT(a_res_after_busy, out_valid |-> $past(busy), "result without work")

  // one result beat per item, never back to back
  `CHK_NEVER(a_no_double, out_valid && $past(out_valid), "result strobe held")

  // status stays within its codes
  `CHK_ASSERT(a_status_code, out_valid |-> (out_item.status <= STS_NOT_FOUND), "bad status")

endmodule

bind channel_window_msgid_tracker cwmt_checker u_cwmt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
